### design/hat_pkg.sv
// shared types and constants for the hash accumulate table
`timescale 1ns / 1ps
package hat_pkg;
  localparam int unsigned SLOT_BITS = 12;
  localparam int unsigned CAPACITY = 1 << SLOT_BITS;
  localparam int unsigned KEY_BITS = 36;
  localparam int unsigned VAL_BITS = 31;
  localparam int unsigned LOAD_LIMIT = (CAPACITY * 7) / 10;
  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_INSERTED    = 3'd0,
    ST_ACCUMULATED = 3'd1,
    ST_ZERO        = 3'd2,
    ST_FULL        = 3'd3,
    ST_OCCUPIED    = 3'd4,
    ST_EMPTY       = 3'd5,
    ST_CLEARED     = 3'd6
  } status_t;

  // hash unit control and result
  typedef struct packed {
    logic start;
  } hash_ctl_t;

  typedef struct packed {
    logic                 done;
    logic [SLOT_BITS-1:0] slot;
  } hash_res_t;
endpackage

### design/hat_ram.sv
// generic single port ram with registered read
`timescale 1ns / 1ps
module hat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### design/hat_hash.sv
// iterative splitmix64 finalizer, one 32x32 partial product per cycle
`timescale 1ns / 1ps
module hat_hash (
  input  logic                          clk,
  input  logic                          rst,
  input  hat_pkg::hash_ctl_t            ctl,
  input  logic [hat_pkg::KEY_BITS:0]    entry_tag,
  output hat_pkg::hash_res_t            res
);
  typedef enum logic [2:0] {H_IDLE, H_MUL, H_MIX2, H_DONE} hstate_t;

  hstate_t     state;
  logic        done;
  logic [63:0] x;
  logic [63:0] acc;
  logic [1:0]  pp;
  logic        round;
  logic [31:0] a_half;
  logic [31:0] c_half;
  logic [63:0] c_sel;
  logic [63:0] prod;
  logic [63:0] pp_shift;

  always_comb begin
    c_sel  = round ? hat_pkg::MIX_C2 : hat_pkg::MIX_C1;
    a_half = pp[1] ? x[63:32] : x[31:0];
    c_half = pp[0] ? c_sel[63:32] : c_sel[31:0];
    prod   = 64'(a_half) * 64'(c_half);
    case (pp)
      2'd0:    pp_shift = prod;
      2'd3:    pp_shift = '0;
      default: pp_shift = {prod[31:0], 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        H_IDLE: begin
          if (ctl.start) begin
            x     <= {{(63 - hat_pkg::KEY_BITS){1'b0}}, entry_tag}
                     ^ ({{(63 - hat_pkg::KEY_BITS){1'b0}}, entry_tag} >> 30);
            acc   <= '0;
            pp    <= 2'd0;
            round <= 1'b0;
            state <= H_MUL;
          end
        end
        H_MUL: begin
          acc <= acc + pp_shift;
          pp  <= pp + 2'd1;
          if (pp == 2'd2) begin
            state <= H_MIX2;
          end
        end
        H_MIX2: begin
          acc <= '0;
          pp  <= 2'd0;
          if (!round) begin
            x     <= acc ^ (acc >> 27);
            round <= 1'b1;
            state <= H_MUL;
          end else begin
            x     <= acc ^ (acc >> 31);
            state <= H_DONE;
          end
        end
        H_DONE: begin
          done  <= 1'b1;
          state <= H_IDLE;
        end
        default: state <= H_IDLE;
      endcase
    end
  end

  assign res.done = done;
  assign res.slot = x[hat_pkg::SLOT_BITS-1:0];
endmodule

### design/hash_accumulate_table.sv
// an add hashes the key and probes slots in turn, a zero addend skips both,
// a read looks up its slot index and a clear wipes the key store (one slot a cycle)
// items are taken one at a time; the hash multiplier and one ram port set the rate
// reset is synchronous and runs a clearing pass over the key store, with stall held high
// meanwhile; configuration writes are taken during the pass
// prime_modulus resets to 2147483647
`timescale 1ns / 1ps
module hash_accumulate_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [1:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     opcode,
  input  logic [hat_pkg::KEY_BITS-1:0]   key,
  input  logic [hat_pkg::VAL_BITS-1:0]   addend,
  input  logic [hat_pkg::SLOT_BITS-1:0]  slot_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     status,
  output logic [hat_pkg::KEY_BITS-1:0]   key_out,
  output logic [hat_pkg::VAL_BITS-1:0]   value_out,
  output logic [hat_pkg::SLOT_BITS-1:0]  slot_out,
  output logic [hat_pkg::SLOT_BITS-1:0]  entry_count_out
);
  localparam int unsigned SB = hat_pkg::SLOT_BITS;
  localparam int unsigned KB = hat_pkg::KEY_BITS;
  localparam int unsigned VB = hat_pkg::VAL_BITS;

  typedef enum logic [3:0] {
    S_WIPE, S_IDLE, S_HASH, S_PROBE_RD, S_PROBE_CHK, S_ACC, S_WR,
    S_READ_RD, S_READ_CHK, S_OUT
  } state_t;

  state_t              state;
  logic [VB-1:0]       prime_modulus;
  logic [SB:0]         entry_count;
  logic [SB:0]         probe_n;
  logic [SB-1:0]       slot;
  logic [SB-1:0]       wipe_addr;
  logic [1:0]          op;
  logic [KB-1:0]       key_q;
  logic [VB-1:0]       addend_q;
  logic [VB:0]         sum;

  // key store and value store ports
  logic                kwe;
  logic [SB-1:0]       kaddr;
  logic [KB:0]         kwdata;
  logic [KB:0]         krdata;
  logic                vwe;
  logic [VB-1:0]       vwdata;
  logic [VB-1:0]       vrdata;

  hat_pkg::hash_ctl_t  hctl;
  hat_pkg::hash_res_t  hres;
  logic [KB:0]         entry_tag;

  assign entry_tag = {1'b0, key_q} + (KB + 1)'(1);

  hat_hash u_hash (
    .clk        (clk),
    .rst        (rst),
    .ctl        (hctl),
    .entry_tag  (entry_tag),
    .res        (hres)
  );

  hat_ram #(.WIDTH(KB + 1), .DEPTH(hat_pkg::CAPACITY)) u_keys (
    .clk (clk), .we (kwe), .addr (kaddr), .wdata (kwdata), .rdata (krdata)
  );

  hat_ram #(.WIDTH(VB), .DEPTH(hat_pkg::CAPACITY)) u_vals (
    .clk (clk), .we (vwe), .addr (kaddr), .wdata (vwdata), .rdata (vrdata)
  );

  // apb register, always ready
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {1'b0, prime_modulus} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_modulus <= '1;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      prime_modulus <= pwdata[VB-1:0];
    end
  end

  assign in_stall = (state != S_IDLE);
  assign hctl.start = (state == S_HASH) && !hres.done && (probe_n == '0);

  // accumulate: single compare and subtract
  assign sum = {1'b0, vrdata} + {1'b0, addend_q};

  always_comb begin
    kwe    = 1'b0;
    vwe    = 1'b0;
    kaddr  = slot;
    kwdata = entry_tag;
    vwdata = addend_q;
    case (state)
      S_WIPE: begin
        kwe    = 1'b1;
        kaddr  = wipe_addr;
        kwdata = '0;
      end
      S_ACC: begin
        vwe    = 1'b1;
        vwdata = (sum >= {1'b0, prime_modulus}) ? VB'(sum - {1'b0, prime_modulus})
                                                 : sum[VB-1:0];
      end
      S_WR: begin
        kwe = 1'b1;
        vwe = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_WIPE;
      wipe_addr   <= '0;
      entry_count <= '0;
      out_valid   <= 1'b0;
      probe_n     <= '0;
      op          <= hat_pkg::OP_READ;
    end else begin
      case (state)
        S_WIPE: begin
          wipe_addr <= wipe_addr + SB'(1);
          if (wipe_addr == '1) begin
            entry_count <= '0;
            // a clear item reports once the pass is done, the reset pass does not
            state       <= (op == hat_pkg::OP_CLEAR) ? S_OUT : S_IDLE;
          end
        end
        S_IDLE: begin
          out_valid <= 1'b0;
          if (in_valid) begin
            op       <= opcode;
            key_q    <= key;
            addend_q <= addend;
            slot     <= slot_index;
            probe_n  <= '0;
            case (opcode)
              hat_pkg::OP_CLEAR: begin
                status    <= hat_pkg::ST_CLEARED;
                key_out   <= '0;
                value_out <= '0;
                slot_out  <= '0;
                wipe_addr <= '0;
                state     <= S_WIPE;
              end
              hat_pkg::OP_ADD: begin
                if (addend == '0) begin
                  status    <= hat_pkg::ST_ZERO;
                  key_out   <= key;
                  value_out <= '0;
                  slot_out  <= '0;
                  state     <= S_OUT;
                end else begin
                  state <= S_HASH;
                end
              end
              default: state <= S_READ_RD;
            endcase
          end
        end
        S_HASH: begin
          if (hres.done) begin
            slot    <= hres.slot;
            probe_n <= '0;
            state   <= S_PROBE_RD;
          end else begin
            probe_n <= (SB + 1)'(1);
          end
        end
        S_PROBE_RD: state <= S_PROBE_CHK;
        S_PROBE_CHK: begin
          if (krdata == entry_tag) begin
            state <= S_ACC;
          end else if (krdata == '0) begin
            if ((SB + 2)'(entry_count) + (SB + 2)'(1) > (SB + 2)'(hat_pkg::LOAD_LIMIT)) begin
              status    <= hat_pkg::ST_FULL;
              key_out   <= key_q;
              value_out <= '0;
              slot_out  <= '0;
              state     <= S_OUT;
            end else begin
              state <= S_WR;
            end
          end else if (probe_n == (SB + 1)'(hat_pkg::CAPACITY - 1)) begin
            status    <= hat_pkg::ST_FULL;
            key_out   <= key_q;
            value_out <= '0;
            slot_out  <= '0;
            state     <= S_OUT;
          end else begin
            probe_n <= probe_n + (SB + 1)'(1);
            slot    <= slot + SB'(1);
            state   <= S_PROBE_RD;
          end
        end
        S_ACC: begin
          status    <= hat_pkg::ST_ACCUMULATED;
          key_out   <= key_q;
          value_out <= vwdata;
          slot_out  <= slot;
          state     <= S_OUT;
        end
        S_WR: begin
          status      <= hat_pkg::ST_INSERTED;
          key_out     <= key_q;
          value_out   <= addend_q;
          slot_out    <= slot;
          entry_count <= entry_count + (SB + 1)'(1);
          state       <= S_OUT;
        end
        S_READ_RD: state <= S_READ_CHK;
        S_READ_CHK: begin
          slot_out <= slot;
          if (krdata != '0) begin
            status    <= hat_pkg::ST_OCCUPIED;
            key_out   <= KB'(krdata - (KB + 1)'(1));
            value_out <= vrdata;
          end else begin
            status    <= hat_pkg::ST_EMPTY;
            key_out   <= '0;
            value_out <= '0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign entry_count_out = entry_count[SB-1:0];
endmodule

### design/hat_checker.sv
// port level checks for the hash accumulate table
`timescale 1ns / 1ps
module hat_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [11:0] entry_count_out
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a second item while busy");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == hat_pkg::ST_CLEARED |-> entry_count_out == '0)
    else $error("clear left entries");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 3'd7)
    else $error("bad status code");
endmodule

bind hash_accumulate_table hat_checker u_hat_checker (
  .clk (clk), .rst (rst), .in_valid (in_valid), .in_stall (in_stall),
  .out_valid (out_valid), .out_stall (out_stall), .status (status),
  .entry_count_out (entry_count_out)
);

### verif/tb_hash_accumulate_table.sv
// self-checking testbench for the hash accumulate table
`timescale 1ns / 1ps
module tb_hash_accumulate_table;
  localparam int unsigned CAPACITY = hat_pkg::CAPACITY;
  localparam int unsigned SLOT_BITS = hat_pkg::SLOT_BITS;
  localparam int unsigned KEY_BITS = hat_pkg::KEY_BITS;
  localparam int unsigned VAL_BITS = hat_pkg::VAL_BITS;
  localparam int unsigned LOAD_LIMIT = hat_pkg::LOAD_LIMIT;
  localparam logic [1:0] ADDR_PRIME = 2'd0;

  // one result transfer as the block reports it
  typedef struct {
    hat_pkg::status_t     st;
    logic [KEY_BITS-1:0]  key;
    logic [VAL_BITS-1:0]  val;
    logic [SLOT_BITS-1:0] slot;
    logic [SLOT_BITS-1:0] count;
  } result_t;

  // one row of the directed table; fixed rows carry a typed-in result
  typedef struct {
    hat_pkg::opcode_t     op;
    logic [KEY_BITS-1:0]  key;
    logic [VAL_BITS-1:0]  addend;
    logic [SLOT_BITS-1:0] slot;
    bit                   fixed;
    result_t              res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           opcode = '0;
  logic [KEY_BITS-1:0]  key = '0;
  logic [VAL_BITS-1:0]  addend = '0;
  logic [SLOT_BITS-1:0] slot_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           status;
  logic [KEY_BITS-1:0]  key_out;
  logic [VAL_BITS-1:0]  value_out;
  logic [SLOT_BITS-1:0] slot_out;
  logic [SLOT_BITS-1:0] entry_count_out;

  // shadow copy of the table and its modulus
  logic [KEY_BITS:0]    table_key [CAPACITY];
  logic [VAL_BITS-1:0]  table_val [CAPACITY];
  logic [12:0]          live_count;
  logic [VAL_BITS-1:0]  prime_mod;
  logic [SLOT_BITS-1:0] used_slots[$];
  logic [KEY_BITS-1:0]  key_pool[$];

  result_t pending_results[$];
  int      errors = 0;
  int      sent_items = 0;
  int      seen_results = 0;
  int      full_hits = 0;
  int      acc_hits = 0;
  bit      gap_free = 1'b0;

  hash_accumulate_table DUT (.*);

  always #10 clk = ~clk;

  // splitmix64 finalizer, masked down to a home slot
  function automatic logic [SLOT_BITS-1:0] home_slot(logic [63:0] x);
    x = x ^ (x >> 30);
    x = x * hat_pkg::MIX_C1;
    x = x ^ (x >> 27);
    x = x * hat_pkg::MIX_C2;
    x = x ^ (x >> 31);
    return x[SLOT_BITS-1:0];
  endfunction

  // works out the result of one item and updates the shadow table
  function automatic result_t table_update(hat_pkg::opcode_t op, logic [KEY_BITS-1:0] k,
                                           logic [VAL_BITS-1:0] a,
                                           logic [SLOT_BITS-1:0] idx);
    result_t r;
    logic [KEY_BITS:0] stored;
    logic [SLOT_BITS-1:0] s;
    logic [32:0] sum;
    bit found;
    bit hole;
    found = 1'b0;
    hole = 1'b0;
    r = '{hat_pkg::ST_CLEARED, '0, '0, '0, '0};
    if (op == hat_pkg::OP_CLEAR) begin
      for (int i = 0; i < CAPACITY; i++) table_key[i] = '0;
      live_count = '0;
      used_slots.delete();
    end else if (op != hat_pkg::OP_ADD) begin
      // reserved opcode behaves as a read
      r.slot = idx;
      if (table_key[idx] != 0) begin
        r.st = hat_pkg::ST_OCCUPIED;
        r.key = KEY_BITS'(table_key[idx] - 1'b1);
        r.val = table_val[idx];
      end else begin
        r.st = hat_pkg::ST_EMPTY;
      end
    end else if (a == 0) begin
      r.st = hat_pkg::ST_ZERO;
      r.key = k;
    end else begin
      stored = {1'b0, k} + (KEY_BITS + 1)'(1);
      s = home_slot({27'd0, stored});
      for (int n = 0; n < CAPACITY; n++) begin
        if (table_key[s] == stored) begin
          found = 1'b1;
          break;
        end
        if (table_key[s] == 0) begin
          hole = 1'b1;
          break;
        end
        s = s + 1'b1;
      end
      r.key = k;
      if (found) begin
        // single conditional subtract, then wrap to 31 bits
        sum = {2'b0, table_val[s]} + {2'b0, a};
        if (sum >= {2'b0, prime_mod}) sum = sum - {2'b0, prime_mod};
        table_val[s] = sum[VAL_BITS-1:0];
        r.st = hat_pkg::ST_ACCUMULATED;
        r.val = table_val[s];
        r.slot = s;
        acc_hits++;
      end else if (!hole || live_count + 1 > LOAD_LIMIT) begin
        r.st = hat_pkg::ST_FULL;
        full_hits++;
      end else begin
        table_key[s] = stored;
        table_val[s] = a;
        live_count = live_count + 1'b1;
        used_slots.push_back(s);
        key_pool.push_back(k);
        r.st = hat_pkg::ST_INSERTED;
        r.val = a;
        r.slot = s;
      end
    end
    r.count = live_count[SLOT_BITS-1:0];
    return r;
  endfunction

  // sender gap: mostly none or short, a few long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (gap_free || p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 100);
  endfunction

  // drive one input transfer; valid stays up when no gap follows
  task automatic send_item(hat_pkg::opcode_t op, logic [KEY_BITS-1:0] k,
                           logic [VAL_BITS-1:0] a, logic [SLOT_BITS-1:0] idx,
                           bit fixed, result_t fixed_res);
    result_t r;
    int g;
    in_valid <= 1'b1;
    opcode <= op;
    key <= k;
    addend <= a;
    slot_index <= idx;
    do @(posedge clk); while (in_stall);
    r = table_update(op, k, a, idx);
    if (fixed) r = fixed_res;
    pending_results.push_back(r);
    sent_items++;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // wait until every expected result has come back, then let the block settle
  task automatic drain();
    if (in_valid) begin
      @(posedge clk);
      in_valid <= 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // two-phase register write, only while the block is idle
  task automatic write_prime(logic [VAL_BITS-1:0] m);
    drain();
    check_field("prdata", {33'd0, prime_mod}, {32'd0, prdata});
    check_field("pready", 64'd1, {63'd0, pready});
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_PRIME;
    pwdata <= {1'b0, m};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    prime_mod = m;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_items(int n);
    int p;
    hat_pkg::opcode_t op;
    logic [KEY_BITS-1:0] k;
    logic [VAL_BITS-1:0] a;
    logic [SLOT_BITS-1:0] idx;
    result_t none;
    none = '{hat_pkg::ST_CLEARED, '0, '0, '0, '0};
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 999);
      k = KEY_BITS'({$urandom(), $urandom()});
      a = VAL_BITS'($urandom());
      idx = SLOT_BITS'($urandom());
      // reuse keys so that most adds accumulate
      if (key_pool.size() != 0 && $urandom_range(0, 99) < 55)
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      if ($urandom_range(0, 99) < 4) a = '0;
      else if ($urandom_range(0, 99) < 5) a = {VAL_BITS{1'b1}};
      else if (prime_mod < 1000 && $urandom_range(0, 1))
        a = VAL_BITS'($urandom_range(1, prime_mod));
      if (p < 8) begin
        op = hat_pkg::OP_CLEAR;
        key_pool.delete();
      end else if (p < 700) begin
        op = hat_pkg::OP_ADD;
      end else begin
        op = (p < 730) ? hat_pkg::OP_RSVD : hat_pkg::OP_READ;
        if (used_slots.size() != 0 && $urandom_range(0, 1))
          idx = used_slots[$urandom_range(0, used_slots.size() - 1)];
      end
      send_item(op, k, a, idx, 1'b0, none);
    end
  endtask

  // result side: random stall runs, short mostly, some long, some quiet stretches
  int stall_left = 0;
  always @(posedge clk) begin
    int p;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      p = $urandom_range(0, 99);
      if (p < 10) begin
        out_stall <= 1'b0;
        stall_left <= $urandom_range(100, 300);
      end else if (p < 15) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(20, 80);
      end else begin
        out_stall <= 1'($urandom_range(0, 1));
        stall_left <= $urandom_range(0, 3);
      end
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t w;
    if (!rst && out_valid && !out_stall) begin
      seen_results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, actual status %0d", $time, status);
      end else begin
        w = pending_results.pop_front();
        check_field("status", 64'(w.st), 64'(status));
        check_field("key_out", 64'(w.key), 64'(key_out));
        check_field("value_out", 64'(w.val), 64'(value_out));
        check_field("slot_out", 64'(w.slot), 64'(slot_out));
        check_field("entry_count_out", 64'(w.count), 64'(entry_count_out));
      end
    end
  end

  initial begin
    #500ms;
    $display("hash_accumulate_table regression: fail");
    $finish;
  end

  initial begin
    row_t rows[$];
    result_t none;
    logic [KEY_BITS-1:0] kmax;
    int wait_cycles;
    none = '{hat_pkg::ST_CLEARED, '0, '0, '0, '0};
    kmax = {KEY_BITS{1'b1}};
    for (int i = 0; i < CAPACITY; i++) begin
      table_key[i] = '0;
      table_val[i] = '0;
    end
    live_count = '0;
    prime_mod = 31'h7fffffff;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed rows: extremes, every opcode, zero addends and reads of empty slots
    rows.push_back('{hat_pkg::OP_READ, '0, '0, 12'd0, 1'b1,
                     '{hat_pkg::ST_EMPTY, '0, '0, 12'd0, '0}});
    rows.push_back('{hat_pkg::OP_ADD, '0, '0, '0, 1'b1,
                     '{hat_pkg::ST_ZERO, '0, '0, '0, '0}});
    rows.push_back('{hat_pkg::OP_ADD, kmax, '0, '0, 1'b1,
                     '{hat_pkg::ST_ZERO, kmax, '0, '0, '0}});
    rows.push_back('{hat_pkg::OP_ADD, kmax, 31'd1, '0, 1'b0, none});
    rows.push_back('{hat_pkg::OP_ADD, kmax, 31'h7fffffff, '0, 1'b0, none});
    rows.push_back('{hat_pkg::OP_ADD, '0, 31'h7fffffff, '0, 1'b0, none});
    rows.push_back('{hat_pkg::OP_ADD, '0, 31'h7ffffffe, '0, 1'b0, none});
    rows.push_back('{hat_pkg::OP_ADD, 36'h5a5a5a5a5, 31'h2aaaaaaa, '0, 1'b0, none});
    rows.push_back('{hat_pkg::OP_ADD, 36'ha5a5a5a5a, 31'h55555555, '0, 1'b0, none});
    rows.push_back('{hat_pkg::OP_ADD, 36'h5a5a5a5a5, 31'h55555555, '0, 1'b0, none});
    rows.push_back('{hat_pkg::OP_READ, '0, '0, 12'hfff, 1'b0, none});
    rows.push_back('{hat_pkg::OP_RSVD, kmax, 31'h7fffffff, 12'h000, 1'b0, none});
    rows.push_back('{hat_pkg::OP_READ, kmax, '0, 12'h555, 1'b0, none});
    rows.push_back('{hat_pkg::OP_RSVD, '0, '0, 12'haaa, 1'b0, none});
    rows.push_back('{hat_pkg::OP_CLEAR, kmax, 31'h7fffffff, 12'hfff, 1'b1,
                     '{hat_pkg::ST_CLEARED, '0, '0, '0, '0}});
    rows.push_back('{hat_pkg::OP_READ, '0, '0, 12'hfff, 1'b1,
                     '{hat_pkg::ST_EMPTY, '0, '0, 12'hfff, '0}});
    rows.push_back('{hat_pkg::OP_ADD, 36'h1, 31'h1, '0, 1'b0, none});
    foreach (rows[i]) begin
      if (rows[i].op == hat_pkg::OP_READ && used_slots.size() != 0 && i == 10)
        rows[i].slot = used_slots[0];
      send_item(rows[i].op, rows[i].key, rows[i].addend, rows[i].slot,
                rows[i].fixed, rows[i].res);
    end

    // smallest modulus, then a back to back burst of inserts
    write_prime(31'd2);
    send_item(hat_pkg::OP_CLEAR, '0, '0, '0, 1'b0, none);
    key_pool.delete();
    gap_free = 1'b1;
    for (int i = 0; i < 500; i++)
      send_item(hat_pkg::OP_ADD, 36'd1000 + KEY_BITS'(i), VAL_BITS'($urandom_range(1, 3)),
                '0, 1'b0, none);
    gap_free = 1'b0;
    random_items(60);
    send_item(hat_pkg::OP_CLEAR, '0, '0, '0, 1'b0, none);
    key_pool.delete();

    write_prime(31'd13);
    random_items(380);
    write_prime(31'd65521);
    random_items(370);
    write_prime(31'h7fffffff);
    random_items(370);

    drain();
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t ns: %0d expected results never arrived", $time, pending_results.size());
    end
    $display("covered %0d items and %0d results over four moduli", sent_items, seen_results);
    $display("with %0d accumulations and %0d rejections at the load limit", acc_hits,
             full_hits);
    if (errors == 0) begin
      $display("hash_accumulate_table regression: pass");
    end else begin
      $display("hash_accumulate_table regression: fail");
    end
    $finish;
  end
endmodule

### sim.f
design/hat_pkg.sv
design/hat_ram.sv
design/hat_hash.sv
design/hash_accumulate_table.sv
design/hat_checker.sv
verif/tb_hash_accumulate_table.sv
